// File: design/rtat_pkg.sv
// ---------------------------------------------------------------------------
// rtat_pkg - range table address translator package
// Shared types, register indexes and window constants.
// ---------------------------------------------------------------------------
`default_nettype none

package rtat_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int ADDR_W  = 64;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;
    localparam int CFG_W   = 2;

    // operation codes carried by i_func
    localparam logic FUNC_WRITE     = 1'b0;
    localparam logic FUNC_TRANSLATE = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_W-1:0] {
        CFG_REMAP_EN    = 2'd0,
        CFG_VMEM_BASE   = 2'd1,
        CFG_ENTRY_COUNT = 2'd2
    } t_cfg_reg;

    // legacy video window
    localparam logic [ADDR_W-1:0] WIN_LO    = 64'h0000_0000_000A_0000;
    localparam logic [ADDR_W-1:0] WIN_MID   = 64'h0000_0000_000B_8000;
    localparam logic [ADDR_W-1:0] WIN_HI    = 64'h0000_0000_000C_0000;
    localparam logic [ADDR_W-1:0] EVEN_MASK = 64'h0000_0000_FFFF_FFFE;
    localparam logic [ADDR_W-1:0] PLANE_ADJ = 64'd2;

    // translate request travelling down the cell row
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_token;

    // table entry load
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] offset;
    } t_entry;

endpackage

`default_nettype wire

// File: design/rtat_remap.sv
// ---------------------------------------------------------------------------
// rtat_remap - legacy window remap
// Two registered steps: low window first, then the text window.
// ---------------------------------------------------------------------------
`default_nettype none

module rtat_remap
    import rtat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic              i_remap_en,
    input  wire logic [ADDR_W-1:0] i_vmem_base,
    output t_token                 o_tok
);

    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              n_s1_valid;
    logic [ADDR_W-1:0] n_s1_addr;
    t_token            r_s2;
    t_token            n_s2;

    // step one: 0xA0000..0xB7FFF
    always_comb begin
        n_s1_valid = i_valid;
        n_s1_addr  = i_addr;
        if (i_remap_en && (i_addr >= WIN_LO) && (i_addr < WIN_MID)) begin
            n_s1_addr = ((i_addr - WIN_LO) << 2) + PLANE_ADJ + i_vmem_base;
        end
    end

    // step two: 0xB8000..0xBFFFF, on the result of step one
    always_comb begin
        n_s2.valid = r_s1_valid;
        n_s2.found = 1'b0;
        n_s2.addr  = r_s1_addr;
        if (i_remap_en && (r_s1_addr >= WIN_MID) && (r_s1_addr < WIN_HI)) begin
            n_s2.addr = (((r_s1_addr & EVEN_MASK) - WIN_MID) << 2)
                        + {{(ADDR_W-1){1'b0}}, r_s1_addr[0]} + i_vmem_base;
        end
    end

    // only the valids are reset; the data follows them unconditionally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2.valid <= n_s2.valid;
        end
        r_s1_addr  <= n_s1_addr;
        r_s2.found <= n_s2.found;
        r_s2.addr  <= n_s2.addr;
    end

    assign o_tok = r_s2;

endmodule

`default_nettype wire

// File: design/rtat_cell.sv
// ---------------------------------------------------------------------------
// rtat_cell - one table entry of the search row
// Holds base, inclusive end and offset; checks the passing request.
// ---------------------------------------------------------------------------
`default_nettype none

module rtat_cell
    import rtat_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr_en,
    input  wire t_entry i_wr,
    input  wire logic   i_active,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_end;
    logic [ADDR_W-1:0] r_offset;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_hit;

    // end kept pre-summed, wrapping modulo 2^64
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_base   <= i_wr.base;
            r_end    <= i_wr.base + i_wr.size;
            r_offset <= i_wr.offset;
        end
    end

    assign w_hit = i_tok.valid && !i_tok.found && i_active
                   && (i_tok.addr >= r_base) && (i_tok.addr <= r_end);

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.addr  = i_tok.addr + r_offset;
        end
    end

    // only the valid is reset; the data follows it unconditionally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.found <= n_tok.found;
        r_tok.addr  <= n_tok.addr;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: design/range_table_address_translator_top.sv
// ---------------------------------------------------------------------------
// range_table_address_translator_top - range table address translator
// Legacy video window remap followed by a first-match search over a row
// of range cells, lowest index first.
// ---------------------------------------------------------------------------
//
//  Channel    Signals                                   Transfer
//  ---------  ----------------------------------------  ----------------------
//  request    start, busy, i_func, i_entry_*, i_addr    start && !busy
//  result     o_valid, o_found, o_translated_addr       o_valid (one cycle)
//  config     i_cfg_we, i_cfg_idx, i_cfg_data           i_cfg_we
//
//  A table write completes at its transfer edge; busy stays low, no result.
//  A translate raises busy; the request passes the two remap steps and then
//  one register per cell in the row, the result strobe comes from the last
//  cell and busy drops after it.
//  Reset (synchronous, active low) clears busy, all in-flight valids and
//  the configuration registers; table contents are undefined until written.
//  The result side cannot stall; each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module range_table_address_translator_top
    import rtat_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_func,
    input  wire logic [IDX_W-1:0]   i_entry_index,
    input  wire logic [ADDR_W-1:0]  i_entry_base,
    input  wire logic [ADDR_W-1:0]  i_entry_size,
    input  wire logic [ADDR_W-1:0]  i_entry_offset,
    input  wire logic [ADDR_W-1:0]  i_addr,
    // result
    output logic                    o_valid,
    output logic                    o_found,
    output logic [ADDR_W-1:0]       o_translated_addr,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_idx,
    input  wire logic [ADDR_W-1:0]  i_cfg_data
);

    // configuration registers
    logic               r_remap_en;
    logic [ADDR_W-1:0]  r_vmem_base;
    logic [COUNT_W-1:0] r_entry_count;

    logic               r_busy;
    logic               n_busy;

    logic               w_accept;
    logic               w_xlate;
    logic               w_write;
    t_entry             w_entry;

    // chain[0] is the remap output, chain[i+1] the output of cell i
    t_token             w_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH:0] w_valid_vec;
    logic [TABLE_DEPTH-1:0] w_active;
    logic [TABLE_DEPTH-1:0] w_wr_sel;

    assign w_accept = start && !r_busy;
    assign w_xlate  = w_accept && (i_func == FUNC_TRANSLATE);
    assign w_write  = w_accept && (i_func == FUNC_WRITE);

    assign w_entry.base   = i_entry_base;
    assign w_entry.size   = i_entry_size;
    assign w_entry.offset = i_entry_offset;

    // config writes; unused index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remap_en    <= 1'b0;
            r_vmem_base   <= '0;
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_REMAP_EN:    r_remap_en    <= i_cfg_data[0];
                CFG_VMEM_BASE:   r_vmem_base   <= i_cfg_data;
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // one translate in flight at a time
    always_comb begin
        n_busy = r_busy;
        priority if (w_xlate) begin
            n_busy = 1'b1;
        end else if (w_chain[TABLE_DEPTH].valid) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    rtat_remap u_remap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_xlate),
        .i_addr      (i_addr),
        .i_remap_en  (r_remap_en),
        .i_vmem_base (r_vmem_base),
        .o_tok       (w_chain[0])
    );

    // cell row: cell i searched only below entry_count; every write index
    // selects one cell, also one at or above entry_count
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_active[g] = (32'(r_entry_count) > g);
        assign w_wr_sel[g] = w_write && (32'(i_entry_index) == g);

        rtat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr_sel[g]),
            .i_wr     (w_entry),
            .i_active (w_active[g]),
            .i_tok    (w_chain[g]),
            .o_tok    (w_chain[g+1])
        );
    end

    for (genvar v = 0; v <= TABLE_DEPTH; v++) begin : g_vvec
        assign w_valid_vec[v] = w_chain[v].valid;
    end

    assign busy              = r_busy;
    assign o_valid           = w_chain[TABLE_DEPTH].valid;
    assign o_found           = w_chain[TABLE_DEPTH].found;
    assign o_translated_addr = w_chain[TABLE_DEPTH].addr;

    // checks
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valid_vec))
        else $error("more than one translate in the cell row");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (w_valid_vec == '0))
        else $error("token in the row while not busy");

    a_xlate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xlate |=> r_busy)
        else $error("busy not raised after translate transfer");

    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !r_busy)
        else $error("busy held after result strobe");

    a_result_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("result strobe without a translate in flight");

endmodule

`default_nettype wire
